@@ design/etfi_pkg.sv @@
// Shared types, widths and helpers for the escape-time fractal iterator.
// No dependencies; every other file of the block imports this package.
package etfi_pkg;

    localparam int DATA_W     = 32;  // signed Q4.28 word
    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 16;
    localparam int STEP_W     = 31;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int PROD_W  = 2 * DATA_W;           // product of two magnitudes
    localparam int SQ_W    = PROD_W + 1;           // signed difference / cross term
    localparam int PT_W    = COORD_BITS + STEP_W;  // pixel times step
    localparam int SAT_IN_W = PROD_W + 4;          // headroom before saturation

    localparam int ESC_A = PROD_W + 1;
    localparam int ESC_B = 2 * FRAC_BITS + 3;
    localparam int ESC_W = (ESC_A > ESC_B) ? ESC_A : ESC_B;
    localparam logic [ESC_W-1:0] ESC_LIMIT = ESC_W'(4) << (2 * FRAC_BITS);

    // fractal kinds; the unused code runs as Mandelbrot
    localparam logic [MODE_W-1:0] MODE_MANDEL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SHIP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_JULIA  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_RE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JULIA_IM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y   = 3'd7;

    localparam logic [COUNT_BITS-1:0] MAX_ITER_RESET = COUNT_BITS'(256);

    typedef struct packed {
        logic [MODE_W-1:0]     mode;
        logic [COUNT_BITS-1:0] max_iterations;
        logic [DATA_W-1:0]     julia_c_real;
        logic [DATA_W-1:0]     julia_c_imag;
        logic [DATA_W-1:0]     view_left;
        logic [DATA_W-1:0]     view_top;
        logic [STEP_W-1:0]     step_x;
        logic [STEP_W-1:0]     step_y;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch pixel coordinates
        logic point_mul;  // pixel times step
        logic init;       // form point, load z and c
        logic mul;        // square and cross products of z
        logic step;       // write next z, bump iteration count
        logic finish;     // latch escape count
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic first;      // no iteration done yet
        logic escaped;    // current z lies outside radius 2
        logic at_limit;   // iteration count reached the limit
    } t_sts;

    localparam logic signed [SAT_IN_W-1:0] SAT_HI =
        {{(SAT_IN_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = ~SAT_HI;

    function automatic logic [DATA_W-1:0] sat_data(input logic signed [SAT_IN_W-1:0] v);
        logic [DATA_W-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[DATA_W-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[DATA_W-1:0];
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ design/etfi_regs.sv @@
// Configuration register file of the escape-time fractal iterator.
// Depends on etfi_pkg for widths, register indexes and the t_cfg struct.
module etfi_regs import etfi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= '0;
            r_cfg.max_iterations <= MAX_ITER_RESET;
            r_cfg.julia_c_real   <= '0;
            r_cfg.julia_c_imag   <= '0;
            r_cfg.view_left      <= '0;
            r_cfg.view_top       <= '0;
            r_cfg.step_x         <= '0;
            r_cfg.step_y         <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MODE:     r_cfg.mode           <= i_cfg_data[MODE_W-1:0];
                CFG_MAX_ITER: r_cfg.max_iterations <= i_cfg_data[COUNT_BITS-1:0];
                CFG_JULIA_RE: r_cfg.julia_c_real   <= i_cfg_data[DATA_W-1:0];
                CFG_JULIA_IM: r_cfg.julia_c_imag   <= i_cfg_data[DATA_W-1:0];
                CFG_LEFT:     r_cfg.view_left      <= i_cfg_data[DATA_W-1:0];
                CFG_TOP:      r_cfg.view_top       <= i_cfg_data[DATA_W-1:0];
                CFG_STEP_X:   r_cfg.step_x         <= i_cfg_data[STEP_W-1:0];
                CFG_STEP_Y:   r_cfg.step_y         <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

@@ design/etfi_ctrl.sv @@
// Sequencer of the escape-time fractal iterator: one-hot state machine.
// Depends on etfi_pkg for the t_cmd and t_sts structs.
module etfi_ctrl import etfi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output logic o_result_valid,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_POINT = 5'b00010,
        ST_INIT  = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_EVAL  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   w_done;

    // last iteration escaped, or the limit was hit
    assign w_done = (!i_sts.first && i_sts.escaped) || i_sts.at_limit;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_POINT;
                end
            end
            ST_POINT: begin
                o_cmd.point_mul = 1'b1;
                n_state         = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_EVAL;
            end
            ST_EVAL: begin
                if (w_done) begin
                    o_cmd.finish = 1'b1;
                    n_valid      = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_MUL;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_busy         = (r_state != ST_IDLE);
    assign o_result_valid = r_valid;

endmodule

@@ design/etfi_dpath.sv @@
// Datapath of the escape-time fractal iterator: point setup, three magnitude
// multipliers, next-z update with saturation, escape test and iteration count.
// Depends on etfi_pkg for widths, modes, structs and sat_data.
module etfi_dpath import etfi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    output logic [COUNT_BITS-1:0] o_escape_count
);

    logic [COORD_BITS-1:0] r_px, r_py;
    logic [PT_W-1:0]       r_prod_x, r_prod_y;
    logic [DATA_W-1:0]     r_z_re, r_z_im, r_c_re, r_c_im;
    logic [PROD_W-1:0]     r_aa, r_bb, r_ab;
    logic                  r_cross_neg;
    logic [COUNT_BITS-1:0] r_done;
    logic [COUNT_BITS-1:0] r_count;

    logic signed [SAT_IN_W-1:0] w_pt_re_sum, w_pt_im_sum;
    logic [DATA_W-1:0]          w_pt_re, w_pt_im;
    logic [DATA_W-1:0]          w_abs_re, w_abs_im;
    logic signed [SQ_W-1:0]     w_diff, w_cross, w_re_sh, w_im_sh;
    logic signed [SAT_IN_W-1:0] w_re_sum, w_im_sum;
    logic [ESC_A-1:0]           w_mag;
    logic                       w_escaped;

    // point: left + x*step_x, top - y*step_y
    assign w_pt_re_sum = SAT_IN_W'($signed(i_cfg.view_left))
                       + $signed(SAT_IN_W'(r_prod_x));
    assign w_pt_im_sum = SAT_IN_W'($signed(i_cfg.view_top))
                       - $signed(SAT_IN_W'(r_prod_y));
    assign w_pt_re = sat_data(w_pt_re_sum);
    assign w_pt_im = sat_data(w_pt_im_sum);

    // magnitudes; abs of the most negative word is 2^31 as unsigned
    assign w_abs_re = r_z_re[DATA_W-1] ? (~r_z_re + DATA_W'(1)) : r_z_re;
    assign w_abs_im = r_z_im[DATA_W-1] ? (~r_z_im + DATA_W'(1)) : r_z_im;

    // next z from registered products, floor via arithmetic shift
    assign w_diff  = $signed({1'b0, r_aa}) - $signed({1'b0, r_bb});
    assign w_cross = r_cross_neg ? -$signed({1'b0, r_ab}) : $signed({1'b0, r_ab});
    assign w_re_sh = w_diff >>> FRAC_BITS;
    assign w_im_sh = w_cross >>> (FRAC_BITS - 1);
    assign w_re_sum = SAT_IN_W'(w_re_sh) + SAT_IN_W'($signed(r_c_re));
    assign w_im_sum = SAT_IN_W'(w_im_sh) + SAT_IN_W'($signed(r_c_im));

    // escape test on the squares of the current z
    assign w_mag     = {1'b0, r_aa} + {1'b0, r_bb};
    assign w_escaped = ESC_W'(w_mag) > ESC_LIMIT;

    assign o_sts.first    = (r_done == '0);
    assign o_sts.escaped  = w_escaped;
    assign o_sts.at_limit = (r_done == i_cfg.max_iterations);

    // iteration count and z are the only reset registers here; init restarts both for each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
            r_z_re <= '0;
            r_z_im <= '0;
        end else if (i_cmd.init) begin
            r_done <= '0;
            if (i_cfg.mode == MODE_JULIA) begin
                r_z_re <= w_pt_re;
                r_z_im <= w_pt_im;
            end else begin
                r_z_re <= '0;
                r_z_im <= '0;
            end
        end else if (i_cmd.step) begin
            r_done <= r_done + COUNT_BITS'(1);
            r_z_re <= sat_data(w_re_sum);
            r_z_im <= sat_data(w_im_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        if (i_cmd.point_mul) begin
            r_prod_x <= r_px * i_cfg.step_x;
            r_prod_y <= r_py * i_cfg.step_y;
        end
        if (i_cmd.init) begin
            if (i_cfg.mode == MODE_JULIA) begin
                r_c_re <= i_cfg.julia_c_real;
                r_c_im <= i_cfg.julia_c_imag;
            end else begin
                r_c_re <= w_pt_re;
                r_c_im <= w_pt_im;
            end
        end
        if (i_cmd.mul) begin
            r_aa        <= w_abs_re * w_abs_re;
            r_bb        <= w_abs_im * w_abs_im;
            r_ab        <= w_abs_re * w_abs_im;
            r_cross_neg <= (i_cfg.mode != MODE_SHIP)
                         & (r_z_re[DATA_W-1] ^ r_z_im[DATA_W-1]);
        end
        if (i_cmd.finish) begin
            r_count <= (!o_sts.first && w_escaped) ? (r_done - COUNT_BITS'(1))
                                                   : i_cfg.max_iterations;
        end
    end

    assign o_escape_count = r_count;

endmodule

@@ design/escape_time_fractal_iterator_core.sv @@
// Escape-time fractal iterator core. Each item runs point multiply and init, then
// multiply/evaluate passes until an iteration escapes or the limit is hit (count+1 iterations on
// escape, else max_iterations). start is taken only while idle, so items do not overlap.
// busy falls in the strobe cycle, so the next start can be taken then.
// Reset (i_rst_n, synchronous, active low): idle, registers to defaults.
// Depends on etfi_pkg, etfi_regs, etfi_ctrl and etfi_dpath.
module escape_time_fractal_iterator_core import etfi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item input
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    // result, one cycle strobe, cannot be held off
    output logic                  o_result_valid,
    output logic [COUNT_BITS-1:0] o_escape_count,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // register file: always ready, writes only expected while idle
    etfi_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // sequencer: idle -> point multiply -> init -> (multiply, evaluate)* -> idle
    etfi_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .o_busy         (busy),
        .o_result_valid (o_result_valid),
        .o_cmd          (w_cmd),
        .i_sts          (w_sts)
    );

    // datapath: products are registered, the evaluate cycle does the
    // escape compare on the squares and the saturating z update in parallel
    etfi_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_escape_count (o_escape_count)
    );

endmodule

@@ tb/escape_time_fractal_iterator_core_test.sv @@
// Self-checking testbench for escape_time_fractal_iterator_core: directed corner cases,
// then random viewports and pixels scored against a cycle-free escape-count predictor.
// Depends on etfi_pkg and the core RTL only.
module escape_time_fractal_iterator_core_test import etfi_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Longest gap between accepted items: a pixel that never escapes at the top limit,
    // plus the longest sender burst. Allow four times that.
    localparam int WATCHDOG_LIMIT = 4 * (2 * 65535 + 5 + 7);

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [COORD_BITS-1:0] i_pixel_x = '0;
    logic [COORD_BITS-1:0] i_pixel_y = '0;
    logic                  o_result_valid;
    logic [COUNT_BITS-1:0] o_escape_count;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    escape_time_fractal_iterator_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_result_valid (o_result_valid),
        .o_escape_count (o_escape_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Register image as the core should hold it; updated on each accepted write.
    t_cfg live_cfg;

    t_pixel                pixel_queue[$];      // items waiting for the driver
    logic [COUNT_BITS-1:0] expected_counts[$];  // predicted escape counts, oldest first
    int                    mismatches = 0;
    int                    gap_left = 0;
    int                    stall_cycles = 0;
    int                    items_sent = 0;      // items handed to the queue
    int                    items_answered = 0;  // results scored against a prediction
    bit                    sender_idles = 1'b1;

    function automatic longint sat_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // Escape count for one pixel under live_cfg. Products are exact 64-bit;
    // >>> floors toward minus infinity, which is what the core's truncation does.
    function automatic logic [COUNT_BITS-1:0] predict_escape(
        input logic [COORD_BITS-1:0] px,
        input logic [COORD_BITS-1:0] py
    );
        longint                pt_re, pt_im, c_re, c_im, re, im, a, b;
        longint unsigned       mag;
        logic [COUNT_BITS-1:0] count;
        count = live_cfg.max_iterations;
        // point may fall far outside the word range: clamp it
        pt_re = sat_word(longint'($signed(live_cfg.view_left))
                         + longint'(px) * longint'(live_cfg.step_x));
        pt_im = sat_word(longint'($signed(live_cfg.view_top))
                         - longint'(py) * longint'(live_cfg.step_y));
        if (live_cfg.mode == MODE_JULIA) begin
            re   = pt_re;
            im   = pt_im;
            c_re = longint'($signed(live_cfg.julia_c_real));
            c_im = longint'($signed(live_cfg.julia_c_imag));
        end else begin
            // mandelbrot, burning ship, and the spare code 3
            re   = 0;
            im   = 0;
            c_re = pt_re;
            c_im = pt_im;
        end
        for (int k = 0; k < live_cfg.max_iterations; k++) begin
            a = re;
            b = im;
            if (live_cfg.mode == MODE_SHIP) begin
                if (a < 0) a = -a;
                if (b < 0) b = -b;
            end
            re  = sat_word(((a * a - b * b) >>> FRAC_BITS) + c_re);
            im  = sat_word(((a * b) >>> (FRAC_BITS - 1)) + c_im);
            // |z|^2 > 4, checked on the exact wide sum
            mag = $unsigned(re * re) + $unsigned(im * im);
            if (mag > (64'd4 << (2 * FRAC_BITS))) begin
                count = COUNT_BITS'(k);
                break;
            end
        end
        return count;
    endfunction

    // Item driver: holds start until taken, inserts idle bursts counted only on
    // cycles the core could have taken an item, so gaps land between items.
    always @(posedge i_clk) begin
        t_pixel next_pix;
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                expected_counts.push_back(predict_escape(i_pixel_x, i_pixel_y));
            end
            if (start && busy) begin
                // core still iterating; keep the item on the port
            end else if (gap_left > 0) begin
                start <= 1'b0;
                if (!busy) gap_left <= gap_left - 1;
            end else if (pixel_queue.size() > 0) begin
                next_pix  = pixel_queue.pop_front();
                i_pixel_x <= next_pix.x;
                i_pixel_y <= next_pix.y;
                start     <= 1'b1;
                if (sender_idles && $urandom_range(0, 2) == 0) begin
                    gap_left <= $urandom_range(1, 7);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result monitor: every strobe must match the oldest prediction.
    always @(posedge i_clk) begin
        logic [COUNT_BITS-1:0] want;
        if (i_rst_n && o_result_valid) begin
            if (expected_counts.size() == 0) begin
                if (mismatches < 10) begin
                    $display("ERROR: escape_count %0d strobed with no item outstanding",
                             o_escape_count);
                end
                mismatches++;
            end else begin
                want = expected_counts.pop_front();
                items_answered++;
                if (o_escape_count !== want) begin
                    if (mismatches < 10) begin
                        $display("ERROR: escape_count expected %0d, got %0d",
                                 want, o_escape_count);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Cycles with no item, result or register write taken.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // One register write; bits above the register width go out as junk on purpose.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_MODE:     live_cfg.mode           = data[MODE_W-1:0];
            CFG_MAX_ITER: live_cfg.max_iterations = data[COUNT_BITS-1:0];
            CFG_JULIA_RE: live_cfg.julia_c_real   = data[DATA_W-1:0];
            CFG_JULIA_IM: live_cfg.julia_c_imag   = data[DATA_W-1:0];
            CFG_LEFT:     live_cfg.view_left      = data[DATA_W-1:0];
            CFG_TOP:      live_cfg.view_top       = data[DATA_W-1:0];
            CFG_STEP_X:   live_cfg.step_x         = data[STEP_W-1:0];
            CFG_STEP_Y:   live_cfg.step_y         = data[STEP_W-1:0];
            default:      ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_pixel(input int x, input int y);
        pixel_queue.push_back(t_pixel'{COORD_BITS'(x), COORD_BITS'(y)});
        items_sent++;
    endtask

    // Wait until every queued item has been answered. Each item yields a
    // result, so the core is idle once the last one arrives.
    task automatic drain;
        while (items_answered != items_sent) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        write_reg(CFG_MODE, ($urandom & ~32'h3) | m);
    endtask

    task automatic write_limit(input int lim);
        write_reg(CFG_MAX_ITER, ($urandom & 32'hFFFF_0000) | (lim & 32'hFFFF));
    endtask

    // Random viewport phase. Most phases frame the interesting region around the
    // set so iteration runs deep; some are pure noise on the view and julia registers.
    task automatic random_phase(input int n_items);
        bit          noise;
        int          span, lim, x, y;
        logic [31:0] base;
        noise = ($urandom_range(0, 4) == 0);
        span  = $urandom_range(0, 1) ? 64 : 4096;
        lim   = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 300) : $urandom_range(0, 40);
        write_reg(CFG_MODE, $urandom);  // all four codes, junk above
        write_limit(lim);
        if (noise) begin
            write_reg(CFG_JULIA_RE, $urandom);
            write_reg(CFG_JULIA_IM, $urandom);
            write_reg(CFG_LEFT, $urandom);
            write_reg(CFG_TOP, $urandom);
            write_reg(CFG_STEP_X, $urandom);
            write_reg(CFG_STEP_Y, $urandom);
        end else begin
            // ~3.0 wide view across span pixels, left in [-2.5,1.5], top in [0.5,2]
            base = (32'd3 << FRAC_BITS) / span;
            write_reg(CFG_STEP_X, $urandom_range(base / 2, base + base / 2));
            write_reg(CFG_STEP_Y, $urandom_range(base / 2, base + base / 2));
            write_reg(CFG_LEFT, $urandom_range(0, 32'd1 << 30) - (32'd5 << 27));
            write_reg(CFG_TOP, (32'd1 << 27) + $urandom_range(0, 32'd3 << 27));
            // julia constant within the unit square
            write_reg(CFG_JULIA_RE, $urandom_range(0, 32'd1 << 29) - (32'd1 << 28));
            write_reg(CFG_JULIA_IM, $urandom_range(0, 32'd1 << 29) - (32'd1 << 28));
        end
        for (int n = 0; n < n_items; n++) begin
            if (noise || $urandom_range(0, 9) == 0) begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end else begin
                x = $urandom_range(0, span - 1);
                y = $urandom_range(0, span - 1);
            end
            push_pixel(x, y);
        end
        drain();
    endtask

    initial begin
        live_cfg                = '0;
        live_cfg.max_iterations = MAX_ITER_RESET;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: zero step, origin view, so every point sits at 0 and
        // runs the full default limit.
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        drain();

        // Classic mandelbrot view, 64 px across; far pixels clamp to the word range.
        write_mode(MODE_MANDEL);
        write_limit(40);
        write_reg(CFG_JULIA_RE, $urandom);
        write_reg(CFG_JULIA_IM, $urandom);
        write_reg(CFG_LEFT, 32'hE000_0000);             // -2.0
        write_reg(CFG_TOP, 32'h1800_0000);              // +1.5
        write_reg(CFG_STEP_X, 32'h80C0_0000);           // 3/64, bit 31 is junk
        write_reg(CFG_STEP_Y, 32'h80C0_0000);
        push_pixel(0, 0);
        push_pixel(43, 32);
        push_pixel(21, 32);
        push_pixel(4095, 0);
        push_pixel(0, 4095);
        push_pixel(4095, 4095);
        drain();

        // Zero iteration limit answers 0 straight away.
        write_limit(0);
        push_pixel(10, 10);
        push_pixel(4095, 0);
        drain();

        // Burning ship over the same view.
        write_mode(MODE_SHIP);
        write_limit(40);
        push_pixel(0, 0);
        push_pixel(32, 24);
        push_pixel(28, 36);
        push_pixel(40, 30);
        drain();

        // Julia, c = -0.8 + 0.156i, view from -1.5.
        write_mode(MODE_JULIA);
        write_reg(CFG_JULIA_RE, -32'sd214748365);
        write_reg(CFG_JULIA_IM, 32'd41875931);
        write_reg(CFG_LEFT, 32'hE800_0000);
        push_pixel(32, 32);
        push_pixel(0, 0);
        push_pixel(20, 30);
        push_pixel(45, 35);
        drain();

        // Spare mode code behaves as mandelbrot.
        write_mode(2'd3);
        write_limit(20);
        write_reg(CFG_LEFT, 32'hE000_0000);
        push_pixel(21, 32);
        push_pixel(0, 0);
        push_pixel(63, 63);
        drain();

        // Register extremes at the top limit; huge starting points escape at once.
        write_mode(MODE_JULIA);
        write_limit(65535);
        write_reg(CFG_JULIA_RE, 32'h8000_0000);
        write_reg(CFG_JULIA_IM, 32'h7FFF_FFFF);
        write_reg(CFG_LEFT, 32'h8000_0000);
        write_reg(CFG_TOP, 32'h7FFF_FFFF);
        write_reg(CFG_STEP_X, 32'hFFFF_FFFF);
        write_reg(CFG_STEP_Y, 32'hFFFF_FFFF);
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(1, 1);
        drain();

        // Top limit on a point that never leaves the origin: one long item.
        write_mode(MODE_MANDEL);
        write_reg(CFG_LEFT, 32'h0);
        write_reg(CFG_TOP, 32'h0);
        write_reg(CFG_STEP_X, 32'h1000_0000);           // 1.0 per pixel
        write_reg(CFG_STEP_Y, 32'h0);
        push_pixel(3, 0);
        push_pixel(0, 0);
        drain();

        // Random part; the last phases run with no sender idling.
        for (int p = 0; p < 20; p++) begin
            if (p >= 17) sender_idles = 1'b0;
            random_phase(50);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
